// ===== rtl/gss_pkg.sv =====
// ----------------------------------------------------------------------------
// gss_pkg: shared types and constants
// Register indexes, reset values and the control types that pass between
// the front end, the back end and the top level.
// ----------------------------------------------------------------------------
package gss_pkg;

  localparam int MAX_GRID_DEF   = 1024;
  localparam int VALUE_BITS_DEF = 20;

  localparam int COEF_W     = 18;
  localparam int SIDE_W     = 11;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 18;
  localparam int IDX_OUT_W  = 10;
  localparam int FRAC       = 16;

  localparam logic [CFG_IDX_W-1:0] REG_DIFF_U    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIFF_V    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FEED_RATE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KILL_RATE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_SIDE = 3'd5;

  localparam logic [COEF_W-1:0] DIFF_U_RST    = 18'd10486;
  localparam logic [COEF_W-1:0] DIFF_V_RST    = 18'd5243;
  localparam logic [COEF_W-1:0] FEED_RATE_RST = 18'd3932;
  localparam logic [COEF_W-1:0] KILL_RATE_RST = 18'd4063;
  localparam logic [COEF_W-1:0] TIME_STEP_RST = 18'd65536;
  localparam logic [SIDE_W-1:0] GRID_SIDE_RST = 11'd256;

  typedef struct packed {
    logic [COEF_W-1:0] diff_u;
    logic [COEF_W-1:0] diff_v;
    logic [COEF_W-1:0] feed_rate;
    logic [COEF_W-1:0] kill_rate;
    logic [COEF_W-1:0] time_step;
    logic [SIDE_W-1:0] grid_side;
  } gss_cfg_t;

  // classification of one cell, made by the front end
  typedef struct packed {
    logic has_prev;   // row above exists, one result for it
    logic interior;   // row above cell needs the full update
    logic last_row;   // cell itself is emitted as border
    logic corner;     // last cell of the grid
    logic first_col;
    logic last_col;
  } gss_flags_t;

  localparam int FLAGS_W = $bits(gss_flags_t);

endpackage

// ===== rtl/gss_in_if.sv =====
// ----------------------------------------------------------------------------
// gss_in_if: input cell channel
// Valid/ready channel carrying one grid cell (u, v).
// ----------------------------------------------------------------------------
interface gss_in_if #(
  parameter int VALUE_BITS = gss_pkg::VALUE_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] u_in;
  logic signed [VALUE_BITS-1:0] v_in;

  modport source (output valid, output u_in, output v_in, input ready);
  modport sink   (input valid, input u_in, input v_in, output ready);
endinterface

// ===== rtl/gss_out_if.sv =====
// ----------------------------------------------------------------------------
// gss_out_if: result cell channel
// Valid/ready channel carrying one updated cell and its position.
// ----------------------------------------------------------------------------
interface gss_out_if #(
  parameter int VALUE_BITS = gss_pkg::VALUE_BITS_DEF
);
  logic                              valid;
  logic                              ready;
  logic signed [VALUE_BITS-1:0]      u_out;
  logic signed [VALUE_BITS-1:0]      v_out;
  logic [gss_pkg::IDX_OUT_W-1:0]     out_row;
  logic [gss_pkg::IDX_OUT_W-1:0]     out_col;
  logic                              last_of_run;
  logic                              frame_done;

  modport source (output valid, output u_out, output v_out, output out_row,
                  output out_col, output last_of_run, output frame_done,
                  input ready);
  modport sink   (input valid, input u_out, input v_out, input out_row,
                  input out_col, input last_of_run, input frame_done,
                  output ready);
endinterface

// ===== rtl/gss_front.sv =====
// ----------------------------------------------------------------------------
// gss_front: cell intake and classification
// Tracks the raster position, clamps the grid side and tags each beat with
// the work the back end has to do for it.
// ----------------------------------------------------------------------------
module gss_front #(
  parameter int MAX_GRID   = gss_pkg::MAX_GRID_DEF,
  parameter int VALUE_BITS = gss_pkg::VALUE_BITS_DEF,
  localparam int CW = $clog2(MAX_GRID)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  gss_pkg::gss_cfg_t            cfg,
  gss_in_if.sink                       in_bus,
  input  logic                         q_full,
  output logic                         q_push,
  output logic signed [VALUE_BITS-1:0] q_u,
  output logic signed [VALUE_BITS-1:0] q_v,
  output logic [CW-1:0]                q_row,
  output logic [CW-1:0]                q_col,
  output gss_pkg::gss_flags_t          q_flags
);

  localparam int SW = ($clog2(MAX_GRID + 1) > gss_pkg::SIDE_W) ?
                      $clog2(MAX_GRID + 1) : gss_pkg::SIDE_W;
  localparam logic [SW-1:0] SIDE_MIN = SW'(3);
  localparam logic [SW-1:0] SIDE_MAX = SW'(MAX_GRID);

  logic [CW-1:0] row_r, row_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [SW-1:0] side_raw, side;
  logic [CW-1:0] r, c;
  logic          at_last_col, at_last_row;

  assign side_raw = SW'(cfg.grid_side);

  always_comb begin
    if (side_raw < SIDE_MIN) begin
      side = SIDE_MIN;
    end else if (side_raw > SIDE_MAX) begin
      side = SIDE_MAX;
    end else begin
      side = side_raw;
    end
  end

  // restart a counter that ran past a shrunk side
  assign c = (SW'(col_r) >= side) ? '0 : col_r;
  assign r = (SW'(row_r) >= side) ? '0 : row_r;

  assign at_last_col = (SW'(c) == side - SW'(1));
  assign at_last_row = (SW'(r) == side - SW'(1));

  assign in_bus.ready = !q_full;
  assign q_push       = in_bus.valid && !q_full;
  assign q_u          = in_bus.u_in;
  assign q_v          = in_bus.v_in;
  assign q_row        = r;
  assign q_col        = c;

  always_comb begin
    q_flags.has_prev  = (r != '0);
    q_flags.interior  = (r != '0) && (r != CW'(1)) && (c != '0) && !at_last_col;
    q_flags.last_row  = at_last_row;
    q_flags.corner    = at_last_row && at_last_col;
    q_flags.first_col = (c == '0);
    q_flags.last_col  = at_last_col;
  end

  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    if (q_push) begin
      if (at_last_col) begin
        col_nxt = '0;
        row_nxt = at_last_row ? '0 : r + CW'(1);
      end else begin
        col_nxt = c + CW'(1);
        row_nxt = r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

endmodule

// ===== rtl/gss_queue.sv =====
// ----------------------------------------------------------------------------
// gss_queue: two-entry queue between front and back end
// Lets the intake run ahead while the back end works on a cell.
// ----------------------------------------------------------------------------
module gss_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output logic [WIDTH-1:0] pop_data
);

  logic [WIDTH-1:0] slot_r [2];
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       count_r, count_nxt;

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign pop_data  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== rtl/gss_back.sv =====
// ----------------------------------------------------------------------------
// gss_back: row stores, stencil update and result register
// Reads the neighbors from the row store one per cycle, runs the Gray-Scott
// update through one shared multiplier and hands results to the output.
// ----------------------------------------------------------------------------
module gss_back #(
  parameter int MAX_GRID   = gss_pkg::MAX_GRID_DEF,
  parameter int VALUE_BITS = gss_pkg::VALUE_BITS_DEF,
  localparam int CW = $clog2(MAX_GRID)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  gss_pkg::gss_cfg_t            cfg,
  input  logic                         q_valid,
  output logic                         q_pop,
  input  logic signed [VALUE_BITS-1:0] q_u,
  input  logic signed [VALUE_BITS-1:0] q_v,
  input  logic [CW-1:0]                q_row,
  input  logic [CW-1:0]                q_col,
  input  gss_pkg::gss_flags_t          q_flags,
  gss_out_if.source                    out_bus
);

  localparam int VB    = VALUE_BITS;
  localparam int DEPTH = 2 * MAX_GRID;
  localparam int AW    = $clog2(DEPTH);
  localparam int MA    = (VB > 20) ? VB : 20;
  localparam int MB    = 45;
  localparam int PW    = MA + MB;
  localparam int TW    = (VB + 19 > 48) ? VB + 19 : 48;
  localparam int LW    = VB + 3;
  localparam int FRAC  = gss_pkg::FRAC;
  localparam int OW    = gss_pkg::IDX_OUT_W;

  localparam logic signed [TW-1:0] UV_MAX = TW'({31{1'b1}});
  localparam logic signed [TW-1:0] T_MAX  = TW'({44{1'b1}});
  localparam logic signed [TW-1:0] V_MAX  = TW'({(VB-1){1'b1}});
  localparam logic [AW-1:0]        HALF   = AW'(MAX_GRID);

  typedef enum logic [4:0] {
    S_IDLE, S_RD_C, S_RD_L, S_RD_R, S_RD_U, S_RD_W, S_LAP,
    S_M1, S_M2, S_M3, S_M4, S_M5, S_M6, S_M7, S_M8, S_M9, S_M10,
    S_EM1, S_EM2
  } state_t;

  function automatic logic signed [TW-1:0] sat(input logic signed [TW-1:0] x,
                                               input logic signed [TW-1:0] mx);
    logic signed [TW-1:0] y;
    begin
      if (x > mx) begin
        y = mx;
      end else if (x < ~mx) begin
        y = ~mx;
      end else begin
        y = x;
      end
      return y;
    end
  endfunction

  state_t state_r;

  // row store, u and v side by side
  logic [2*VB-1:0] mem [DEPTH];
  logic [2*VB-1:0] rdata_r;
  logic [AW-1:0]   raddr;
  logic            mem_we;

  logic signed [VB-1:0] u_r, v_r;
  logic [CW-1:0]        row_r, col_r;
  gss_pkg::gss_flags_t  flg_r;

  logic signed [VB-1:0] cu_r, cv_r, lu_r, lv_r, ru_r, rv_r, upu_r, upv_r;
  logic signed [LW-1:0] lapu_r, lapv_r;
  logic signed [TW-1:0] uv_r, uvv_r, tu_r, tv_r;
  logic signed [PW-1:0] prod_r;
  logic signed [VB-1:0] nu_r, nv_r;

  logic signed [MA-1:0] mul_a;
  logic signed [MB-1:0] mul_b;
  logic signed [PW:0]   rnd_full;
  logic signed [TW-1:0] rnd_t;

  logic [AW-1:0] base_cur, base_prv, a_cur, a_prv, a_left, a_right;
  logic          out_free;
  logic          emit;

  logic signed [VB-1:0] rd_u, rd_v;

  assign rd_u = rdata_r[2*VB-1:VB];
  assign rd_v = rdata_r[VB-1:0];

  assign base_cur = row_r[0] ? HALF : '0;
  assign base_prv = row_r[0] ? '0 : HALF;
  assign a_cur    = base_cur + AW'(col_r);
  assign a_prv    = base_prv + AW'(col_r);
  assign a_left   = flg_r.first_col ? a_prv : a_prv - AW'(1);
  assign a_right  = flg_r.last_col ? a_prv : a_prv + AW'(1);

  always_comb begin
    case (state_r)
      S_RD_C:  raddr = a_prv;
      S_RD_L:  raddr = a_left;
      S_RD_R:  raddr = a_right;
      default: raddr = a_cur;
    endcase
  end

  assign mem_we = (state_r == S_RD_W);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[a_cur] <= {u_r, v_r};
    end
    rdata_r <= mem[raddr];
  end

  // multiplier operand select
  always_comb begin
    case (state_r)
      S_M1: begin
        mul_a = MA'(cv_r);
        mul_b = MB'(cu_r);
      end
      S_M3: begin
        mul_a = MA'(cv_r);
        mul_b = MB'(uv_r);
      end
      S_M4: begin
        mul_a = $signed(MA'(cfg.feed_rate));
        mul_b = $signed(MB'(1) <<< FRAC) - MB'(cu_r);
      end
      S_M5: begin
        mul_a = $signed(MA'(cfg.diff_u));
        mul_b = MB'(lapu_r);
      end
      S_M6: begin
        mul_a = $signed(MA'({1'b0, cfg.feed_rate} + {1'b0, cfg.kill_rate}));
        mul_b = MB'(cv_r);
      end
      S_M7: begin
        mul_a = $signed(MA'(cfg.diff_v));
        mul_b = MB'(lapv_r);
      end
      S_M8: begin
        mul_a = $signed(MA'(cfg.time_step));
        mul_b = MB'(sat(tu_r, T_MAX));
      end
      S_M9: begin
        mul_a = $signed(MA'(cfg.time_step));
        mul_b = MB'(sat(tv_r, T_MAX));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // round half up, then floor
  assign rnd_full = ((PW+1)'(prod_r) + (PW+1)'(1 <<< (FRAC - 1))) >>> FRAC;
  assign rnd_t    = TW'(rnd_full);

  assign out_free = !out_bus.valid || out_bus.ready;
  assign emit     = ((state_r == S_EM1) || (state_r == S_EM2)) && out_free;
  assign q_pop    = (state_r == S_IDLE) && q_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      out_bus.valid <= 1'b0;
    end else begin
      // load a new beat, or drop the one taken by the sink
      if (emit) begin
        out_bus.valid <= 1'b1;
      end else if (out_bus.valid && out_bus.ready) begin
        out_bus.valid <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            u_r     <= q_u;
            v_r     <= q_v;
            row_r   <= q_row;
            col_r   <= q_col;
            flg_r   <= q_flags;
            state_r <= S_RD_C;
          end
        end
        S_RD_C: state_r <= S_RD_L;
        S_RD_L: begin
          cu_r    <= rd_u;
          cv_r    <= rd_v;
          state_r <= S_RD_R;
        end
        S_RD_R: begin
          lu_r    <= rd_u;
          lv_r    <= rd_v;
          state_r <= S_RD_U;
        end
        S_RD_U: begin
          ru_r    <= rd_u;
          rv_r    <= rd_v;
          state_r <= S_RD_W;
        end
        S_RD_W: begin
          upu_r <= rd_u;
          upv_r <= rd_v;
          nu_r  <= cu_r;
          nv_r  <= cv_r;
          if (flg_r.interior) begin
            state_r <= S_LAP;
          end else if (flg_r.has_prev) begin
            state_r <= S_EM1;
          end else if (flg_r.last_row) begin
            state_r <= S_EM2;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_LAP: begin
          lapu_r <= LW'(lu_r) + LW'(ru_r) + LW'(upu_r) + LW'(u_r) - (LW'(cu_r) <<< 2);
          lapv_r <= LW'(lv_r) + LW'(rv_r) + LW'(upv_r) + LW'(v_r) - (LW'(cv_r) <<< 2);
          state_r <= S_M1;
        end
        S_M1: begin
          prod_r  <= mul_a * mul_b;
          state_r <= S_M2;
        end
        S_M2: begin
          uv_r    <= sat(rnd_t, UV_MAX);
          state_r <= S_M3;
        end
        S_M3: begin
          prod_r  <= mul_a * mul_b;
          state_r <= S_M4;
        end
        S_M4: begin
          uvv_r   <= rnd_t;
          prod_r  <= mul_a * mul_b;
          state_r <= S_M5;
        end
        S_M5: begin
          tu_r    <= rnd_t - uvv_r;
          prod_r  <= mul_a * mul_b;
          state_r <= S_M6;
        end
        S_M6: begin
          tu_r    <= tu_r + rnd_t;
          prod_r  <= mul_a * mul_b;
          state_r <= S_M7;
        end
        S_M7: begin
          tv_r    <= uvv_r - rnd_t;
          prod_r  <= mul_a * mul_b;
          state_r <= S_M8;
        end
        S_M8: begin
          tv_r    <= tv_r + rnd_t;
          prod_r  <= mul_a * mul_b;
          state_r <= S_M9;
        end
        S_M9: begin
          nu_r    <= VB'(sat(TW'(cu_r) + rnd_t, V_MAX));
          prod_r  <= mul_a * mul_b;
          state_r <= S_M10;
        end
        S_M10: begin
          nv_r    <= VB'(sat(TW'(cv_r) + rnd_t, V_MAX));
          state_r <= S_EM1;
        end
        S_EM1: begin
          if (out_free) begin
            out_bus.u_out       <= nu_r;
            out_bus.v_out       <= nv_r;
            out_bus.out_row     <= OW'(row_r - CW'(1));
            out_bus.out_col     <= OW'(col_r);
            out_bus.last_of_run <= 1'b0;
            out_bus.frame_done  <= 1'b0;
            state_r             <= flg_r.last_row ? S_EM2 : S_IDLE;
          end
        end
        S_EM2: begin
          if (out_free) begin
            out_bus.u_out       <= u_r;
            out_bus.v_out       <= v_r;
            out_bus.out_row     <= OW'(row_r);
            out_bus.out_col     <= OW'(col_r);
            out_bus.last_of_run <= 1'b1;
            out_bus.frame_done  <= flg_r.corner;
            state_r             <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/gray_scott_stencil_step.sv =====
// ----------------------------------------------------------------------------
// gray_scott_stencil_step: one Gray-Scott Euler step over a streamed grid
// Path from accept to result valid, interior cell: queue, row-store reads,
//   Laplacian, 10 multiplier steps, result beat; border cells skip Laplacian and multiplier.
// The back end takes a new cell only after it has handed out the last one's results;
//   the one multiplier and row-store port set the pace.
// Reset clears counters, queue and output valid; the row stores keep no reset.
// ----------------------------------------------------------------------------
module gray_scott_stencil_step #(
  parameter int MAX_GRID   = gss_pkg::MAX_GRID_DEF,
  parameter int VALUE_BITS = gss_pkg::VALUE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  gss_in_if.sink                            in_bus,
  gss_out_if.source                         out_bus,
  input  logic                              cfg_we,
  input  logic [gss_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [gss_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int CW = $clog2(MAX_GRID);
  localparam int VB = VALUE_BITS;
  localparam int EW = 2 * VB + 2 * CW + gss_pkg::FLAGS_W;

  gss_pkg::gss_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.diff_u    <= gss_pkg::DIFF_U_RST;
      cfg_r.diff_v    <= gss_pkg::DIFF_V_RST;
      cfg_r.feed_rate <= gss_pkg::FEED_RATE_RST;
      cfg_r.kill_rate <= gss_pkg::KILL_RATE_RST;
      cfg_r.time_step <= gss_pkg::TIME_STEP_RST;
      cfg_r.grid_side <= gss_pkg::GRID_SIDE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        gss_pkg::REG_DIFF_U:    cfg_r.diff_u    <= cfg_data;
        gss_pkg::REG_DIFF_V:    cfg_r.diff_v    <= cfg_data;
        gss_pkg::REG_FEED_RATE: cfg_r.feed_rate <= cfg_data;
        gss_pkg::REG_KILL_RATE: cfg_r.kill_rate <= cfg_data;
        gss_pkg::REG_TIME_STEP: cfg_r.time_step <= cfg_data;
        gss_pkg::REG_GRID_SIDE: cfg_r.grid_side <= cfg_data[gss_pkg::SIDE_W-1:0];
        default: ;
      endcase
    end
  end

  logic                 q_full, q_push, q_pop, q_valid;
  logic signed [VB-1:0] f_u, f_v, b_u, b_v;
  logic [CW-1:0]        f_row, f_col, b_row, b_col;
  gss_pkg::gss_flags_t  f_flags, b_flags;
  logic [EW-1:0]        q_wdata, q_rdata;

  gss_front #(
    .MAX_GRID   (MAX_GRID),
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .in_bus  (in_bus),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_u     (f_u),
    .q_v     (f_v),
    .q_row   (f_row),
    .q_col   (f_col),
    .q_flags (f_flags)
  );

  assign q_wdata = {f_u, f_v, f_row, f_col, f_flags};

  gss_queue #(
    .WIDTH (EW)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_data  (q_rdata)
  );

  assign {b_u, b_v, b_row, b_col, b_flags} = q_rdata;

  gss_back #(
    .MAX_GRID   (MAX_GRID),
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .q_u     (b_u),
    .q_v     (b_v),
    .q_row   (b_row),
    .q_col   (b_col),
    .q_flags (b_flags),
    .out_bus (out_bus)
  );

endmodule
